### design/gray_mirror_line_stream_defines.svh
// Assertion macros for the gray mirror line stream block.
// Define NO_ASSERTIONS to compile them away; needs clk and rst_n in scope.
`ifndef GRAY_MIRROR_LINE_STREAM_DEFINES_SVH
`define GRAY_MIRROR_LINE_STREAM_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Implication in the same cycle.
`define GMLS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gmls: same-cycle check failed");
// Implication in the next cycle.
`define GMLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gmls: next-cycle check failed");
`else
`define GMLS_ASSERT_SAME(lbl, ante, cons)
`define GMLS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### design/gmls_pkg.sv
// Shared types and constants for the gray mirror line stream block.
// No dependencies.
package gmls_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int ROW_WIDTH_W   = 11;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;
  localparam int GRAY_W        = 8;
  localparam int QUEUE_DEPTH   = 4;

  // Weights in thousandths; the weighted sum stays below 2**18
  localparam int SUM_W   = 18;
  localparam int W_RED   = 210;
  localparam int W_GREEN = 720;
  localparam int W_BLUE  = 70;

  // Divide by 1000 as multiply by ceil(2**26 / 1000) and shift; exact for sums up to 255000
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 17'd67109;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_item_t;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic              row_end;
  } out_item_t;

  // What the back end does for one command
  typedef struct packed {
    logic rd;
    logic wr;
    logic last;
  } cmd_flags_t;

  localparam int FLAGS_W = $bits(cmd_flags_t);

endpackage

### design/gray_mirror_line_stream.sv
// Top level of the gray mirror line stream block: grayscale with horizontal flip.
// Depends on gmls_pkg, gmls_front, gmls_queue, gmls_back and the defines header.
//
//   port group   direction  handshake            payload
//   in_*         input      in_valid / in_stall   gmls_pkg::in_item_t
//   out_*        output     out_valid / out_stall gmls_pkg::out_item_t
//   cfg_*        input      cfg_we                cfg_wdata (row width)
//
// One item per clock while in_stall is low; commands pass through two arithmetic stages
// and the command queue, results through the line store read and the output register.
// Reset (rst_n low, synchronous) clears all control state; the line store is not
// cleared, since only written entries are ever read. in_stall rises only when the
// command queue is full and the front pipeline is loaded; out_stall is absorbed by
// an output register and one hold slot before the queue backs up.
`include "gray_mirror_line_stream_defines.svh"

module gray_mirror_line_stream #(
  parameter int MAX_WIDTH = gmls_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gmls_pkg::ROW_WIDTH_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gmls_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gmls_pkg::out_item_t              out_item
);

  localparam int AW    = $clog2(2 * MAX_WIDTH);
  localparam int CMD_W = gmls_pkg::FLAGS_W + 2 * AW + gmls_pkg::GRAY_W;

  logic             q_push, q_pop, q_full, q_empty;
  logic [CMD_W-1:0] q_wdata, q_rdata;

  // Front: bookkeeping of columns, banks and the pending row, plus gray arithmetic
  gmls_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cmd_push  (q_push),
    .cmd_data  (q_wdata),
    .q_full    (q_full)
  );

  // Queue: decouple the two halves so that each may stall on its own
  gmls_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back: line store writes and mirrored reads, result buffering
  gmls_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Never push into a full queue, never pop an empty one
  `GMLS_ASSERT_SAME(a_push_room, q_push, !q_full)
  `GMLS_ASSERT_SAME(a_pop_data, q_pop, !q_empty)
  // The input side stalls only behind a full queue
  `GMLS_ASSERT_SAME(a_stall_full, in_stall, q_full)
  // A lone push into an empty queue leaves it non-empty
  `GMLS_ASSERT_NEXT(a_push_fill, q_push && !q_pop && q_empty, !q_empty)

endmodule

### design/gmls_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gmls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/gmls_queue.sv
// Short command queue between the front and back ends.
// Depends on gmls_pkg for the default depth.
module gmls_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = gmls_pkg::QUEUE_DEPTH,
  localparam int PW   = $clog2(DEPTH),
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

  assign rdata = slot_r[rptr_r];
  assign full  = (cnt_r == CNTW'(DEPTH));
  assign empty = (cnt_r == '0);

endmodule

### design/gmls_front.sv
// Front end: accepts items, keeps row and bank bookkeeping, computes gray.
// Depends on gmls_pkg; feeds gmls_queue with packed commands.
module gmls_front #(
  parameter int MAX_WIDTH = gmls_pkg::MAX_WIDTH_DEF,
  localparam int AW       = $clog2(2 * MAX_WIDTH),
  localparam int CMD_W    = gmls_pkg::FLAGS_W + 2 * AW + gmls_pkg::GRAY_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gmls_pkg::ROW_WIDTH_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gmls_pkg::in_item_t               in_item,
  output logic                             cmd_push,
  output logic [CMD_W-1:0]                 cmd_data,
  input  logic                             q_full
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int LW    = $clog2(MAX_WIDTH + 1);
  localparam int CMPW  = (LW > gmls_pkg::ROW_WIDTH_W) ? LW : gmls_pkg::ROW_WIDTH_W;
  localparam int SW    = gmls_pkg::SUM_W;
  localparam int PRODW = gmls_pkg::SUM_W + gmls_pkg::RECIP_W;
  localparam int GW    = gmls_pkg::GRAY_W;

  logic [gmls_pkg::ROW_WIDTH_W-1:0] row_width_r;
  logic [CW-1:0] wcol_r, wcol_nxt;
  logic [CW-1:0] rpos_r, rpos_nxt;
  logic [LW-1:0] plen_r, plen_nxt;
  logic          bank_r, bank_nxt;
  logic          pend_r, pend_nxt;

  logic            adv, accept, is_pix, row_done;
  logic [CMPW-1:0] rw_ext, w_eff, col_inc;
  logic [CW-1:0]   rd_col;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [SW-1:0]   sum;
  gmls_pkg::cmd_flags_t flags;

  // Stage A: weighted sum
  logic                 a_valid_r;
  gmls_pkg::cmd_flags_t a_flags_r;
  logic [AW-1:0]        a_rd_addr_r, a_wr_addr_r;
  logic [SW-1:0]        a_sum_r;
  // Stage B: scaled gray
  logic                 b_valid_r;
  gmls_pkg::cmd_flags_t b_flags_r;
  logic [AW-1:0]        b_rd_addr_r, b_wr_addr_r;
  logic [GW-1:0]        b_gray_r;
  logic [PRODW-1:0]     prod;

  assign adv      = !(b_valid_r && q_full);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign is_pix   = (in_item.func == gmls_pkg::FUNC_PIXEL);

  // Clamp the configured width to 1..MAX_WIDTH
  assign rw_ext = CMPW'(row_width_r);
  always_comb begin
    if (rw_ext == '0) begin
      w_eff = CMPW'(1);
    end else if (rw_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = rw_ext;
    end
  end

  assign col_inc  = CMPW'(wcol_r) + CMPW'(1);
  assign row_done = (col_inc >= w_eff);

  // Read the finished row from its last column backwards
  assign rd_col  = CW'(plen_r - LW'(1) - LW'(rpos_r));
  assign rd_addr = bank_r ? AW'(rd_col) : AW'(MAX_WIDTH) + AW'(rd_col);
  assign wr_addr = bank_r ? AW'(MAX_WIDTH) + AW'(wcol_r) : AW'(wcol_r);

  always_comb begin
    flags.rd   = pend_r;
    flags.wr   = is_pix;
    flags.last = ((LW'(rpos_r) + LW'(1)) == plen_r);
  end

  always_comb begin
    wcol_nxt = wcol_r;
    rpos_nxt = rpos_r;
    plen_nxt = plen_r;
    bank_nxt = bank_r;
    pend_nxt = pend_r;
    if (accept) begin
      if (pend_r) begin
        if (flags.last) begin
          pend_nxt = 1'b0;
          rpos_nxt = '0;
        end else begin
          rpos_nxt = rpos_r + CW'(1);
        end
      end
      if (is_pix) begin
        if (row_done) begin
          // A fresh row drops whatever of the old one is still unread
          plen_nxt = LW'(col_inc);
          pend_nxt = 1'b1;
          rpos_nxt = '0;
          bank_nxt = !bank_r;
          wcol_nxt = '0;
        end else begin
          wcol_nxt = CW'(col_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= gmls_pkg::ROW_WIDTH_RESET;
      wcol_r      <= '0;
      rpos_r      <= '0;
      plen_r      <= '0;
      bank_r      <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_width_r <= cfg_wdata;
      end
      wcol_r <= wcol_nxt;
      rpos_r <= rpos_nxt;
      plen_r <= plen_nxt;
      bank_r <= bank_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign sum = SW'(gmls_pkg::W_RED)   * SW'(in_item.red)
             + SW'(gmls_pkg::W_GREEN) * SW'(in_item.green)
             + SW'(gmls_pkg::W_BLUE)  * SW'(in_item.blue);

  assign prod = PRODW'(a_sum_r) * PRODW'(gmls_pkg::RECIP_1000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (adv) begin
      // Drop drains that neither read nor write
      a_valid_r <= accept && (flags.rd || flags.wr);
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_flags_r   <= flags;
      a_rd_addr_r <= rd_addr;
      a_wr_addr_r <= wr_addr;
      a_sum_r     <= sum;
      b_flags_r   <= a_flags_r;
      b_rd_addr_r <= a_rd_addr_r;
      b_wr_addr_r <= a_wr_addr_r;
      b_gray_r    <= prod[gmls_pkg::RECIP_SHIFT +: GW];
    end
  end

  assign cmd_push = b_valid_r && !q_full;
  assign cmd_data = {b_flags_r, b_rd_addr_r, b_wr_addr_r, b_gray_r};

endmodule

### design/gmls_back.sv
// Back end: executes commands on the line store and holds results for output.
// Depends on gmls_pkg and gmls_ram; drains gmls_queue.
module gmls_back #(
  parameter int MAX_WIDTH = gmls_pkg::MAX_WIDTH_DEF,
  localparam int AW       = $clog2(2 * MAX_WIDTH),
  localparam int CMD_W    = gmls_pkg::FLAGS_W + 2 * AW + gmls_pkg::GRAY_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  logic [CMD_W-1:0]    q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output gmls_pkg::out_item_t out_item
);

  localparam int GW = gmls_pkg::GRAY_W;

  gmls_pkg::cmd_flags_t c_flags;
  logic [AW-1:0]        c_rd_addr, c_wr_addr;
  logic [GW-1:0]        c_gray, ram_rdata;

  logic          rv_r, rv_nxt, rl_r;
  logic          out_valid_r, out_valid_nxt, out_end_r, out_end_nxt;
  logic [GW-1:0] out_gray_r, out_gray_nxt;
  logic          hold_valid_r, hold_valid_nxt, hold_end_r, hold_end_nxt;
  logic [GW-1:0] hold_gray_r, hold_gray_nxt;
  logic          take, room;
  logic [1:0]    occ;

  assign {c_flags, c_rd_addr, c_wr_addr, c_gray} = q_rdata;

  // At most two results in flight or waiting: output register and hold slot
  assign take = out_valid_r && !out_stall;
  assign occ  = {1'b0, out_valid_r} + {1'b0, hold_valid_r} + {1'b0, rv_r}
              - {1'b0, take};
  assign room = (occ < 2'd2);
  assign q_pop = !q_empty && (!c_flags.rd || room);

  gmls_ram #(
    .WIDTH (GW),
    .DEPTH (2 * MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (q_pop && c_flags.wr),
    .waddr (c_wr_addr),
    .wdata (c_gray),
    .raddr (c_rd_addr),
    .rdata (ram_rdata)
  );

  assign rv_nxt = q_pop && c_flags.rd;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_gray_nxt   = out_gray_r;
    out_end_nxt    = out_end_r;
    hold_valid_nxt = hold_valid_r;
    hold_gray_nxt  = hold_gray_r;
    hold_end_nxt   = hold_end_r;
    if (!out_valid_r || take) begin
      // Advance the oldest result into the output register
      out_valid_nxt = hold_valid_r || rv_r;
      if (hold_valid_r) begin
        out_gray_nxt   = hold_gray_r;
        out_end_nxt    = hold_end_r;
        hold_valid_nxt = rv_r;
        hold_gray_nxt  = ram_rdata;
        hold_end_nxt   = rl_r;
      end else begin
        out_gray_nxt = ram_rdata;
        out_end_nxt  = rl_r;
      end
    end else if (rv_r) begin
      hold_valid_nxt = 1'b1;
      hold_gray_nxt  = ram_rdata;
      hold_end_nxt   = rl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      rv_r         <= rv_nxt;
      out_valid_r  <= out_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rl_r        <= c_flags.last;
    out_gray_r  <= out_gray_nxt;
    out_end_r   <= out_end_nxt;
    hold_gray_r <= hold_gray_nxt;
    hold_end_r  <= hold_end_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_item.gray    = out_gray_r;
  assign out_item.row_end = out_end_r;

endmodule
